// ----- design/gtt_pkg.sv -----
// Package for the guarded transition table checker.
// Holds sizes, command and register codes, the sequencer states and the check select struct.
// No dependencies.
package gtt_pkg;

   localparam int TABLE_WORDS      = 1024;
   localparam int MAX_GUARDS       = 8;
   localparam int MAX_ROWS         = 128;
   localparam int ROW_HEADER_WORDS = 2;

   localparam int ADDR_W   = $clog2(TABLE_WORDS);
   localparam int GUARD_W  = $clog2(MAX_GUARDS);
   localparam int ROW_W    = $clog2(MAX_ROWS + 1);
   localparam int STRIDE_W = $clog2(MAX_GUARDS + ROW_HEADER_WORDS + 1);
   localparam int BASE_W   = $clog2(MAX_ROWS * (MAX_GUARDS + ROW_HEADER_WORDS) + 1);

   localparam logic [1:0] CMD_WRITE_TABLE  = 2'd0;
   localparam logic [1:0] CMD_WRITE_STATUS = 2'd1;
   localparam logic [1:0] CMD_EVALUATE     = 2'd2;

   localparam logic [1:0] CSR_TRANSITION_COUNT = 2'd0;
   localparam logic [1:0] CSR_GUARD_COUNT      = 2'd1;
   localparam logic [1:0] CSR_GUARD_KIND_MASK  = 2'd2;
   localparam logic [1:0] CSR_WILDCARD_VALUE   = 2'd3;

   typedef enum logic [4:0] {
      S_IDLE  = 5'b00001,
      S_ROW   = 5'b00010,
      S_READ  = 5'b00100,
      S_CHECK = 5'b01000,
      S_DONE  = 5'b10000
   } seq_state_type;

   // Tells the check unit what the word under test is.
   typedef struct packed {
      logic hdr_src;
      logic hdr_req;
      logic mask_test;
   } chk_sel_type;

endpackage

// ----- design/gtt_word_check.sv -----
// Shared compare unit of the transition checker: tests one table word at a time.
// Depends on gtt_pkg for chk_sel_type.
module gtt_word_check import gtt_pkg::*; (
   input  chk_sel_type sel,
   input  logic [31:0] word,
   input  logic [31:0] current_state,
   input  logic [31:0] requested_state,
   input  logic [31:0] status,
   input  logic [31:0] wildcard_word,
   output logic        pass
);

   always_comb begin
      priority if (sel.hdr_src) begin
         pass = (word == current_state);
      end else if (sel.hdr_req) begin
         pass = (word == requested_state);
      end else if (sel.mask_test) begin
         pass = ((status & word) == word);
      end else begin
         pass = (status == word) || (word == wildcard_word);
      end
   end

endmodule

// ----- design/guarded_transition_table_fsm.sv -----
// Top level of the guarded transition table checker: table memory, status registers,
// configuration registers and the scan sequencer. Depends on gtt_pkg and gtt_word_check.
//
// Table and status writes give no result. An evaluate item scans the rows one word at a
// time through a single compare unit: each row opens with a start step (S_ROW), then a
// memory read (S_READ) and a compare (S_CHECK) per word tested until the first mismatch.
// Rows are taken as transition_count capped at 128 and at the rows that fit in the
// 1024-word memory, and guards as guard_count clamped to one..eight. A scan ends in S_DONE,
// which waits for the output register to free up, and the input is not ready while it
// runs. The registered memory read port is why each word needs a read step before its
// compare. A finished result waits in the output register while new items are taken.
module guarded_transition_table_fsm import gtt_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [1:0]  req_cmd,
   input  logic [9:0]  req_word_index,
   input  logic [2:0]  req_guard_index,
   input  logic [31:0] req_word_value,
   input  logic [31:0] req_current_state,
   input  logic [31:0] req_requested_state,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [31:0] rsp_next_state,
   output logic        rsp_granted,
   input  logic        csr_write_enable,
   input  logic [1:0]  csr_index,
   input  logic [31:0] csr_write_data
);

   logic [31:0] table_mem [TABLE_WORDS];
   logic [31:0] rd_data_ff;
   logic [31:0] status_ff [MAX_GUARDS];

   logic [7:0]  transition_count_ff;
   logic [3:0]  guard_count_ff;
   logic [7:0]  guard_kind_mask_ff;
   logic [31:0] wildcard_value_ff;

   seq_state_type state_ff, state_in;
   logic [ROW_W-1:0]    row_ff, row_in;
   logic [BASE_W-1:0]   base_ff, base_in;
   logic [ADDR_W-1:0]   addr_ff, addr_in;
   logic [STRIDE_W-1:0] word_ff, word_in;
   logic [31:0]         cur_ff, cur_in;
   logic [31:0]         reqst_ff, reqst_in;
   logic                grant_ff, grant_in;

   logic        rsp_valid_ff, rsp_valid_in;
   logic [31:0] rsp_next_state_ff, rsp_next_state_in;
   logic        rsp_granted_ff, rsp_granted_in;

   logic                req_accept;
   logic [ROW_W-1:0]    rows_eff;
   logic [3:0]          gc_eff;
   logic [STRIDE_W-1:0] stride;
   logic [GUARD_W-1:0]  guard_sel;
   logic                row_past_end;
   chk_sel_type         chk_sel;
   logic                chk_pass;

   assign req_ready  = (state_ff == S_IDLE);
   assign req_accept = req_valid && req_ready;

   // Row count saturates at MAX_ROWS; guard count is clamped to one..MAX_GUARDS.
   always_comb begin
      if (32'(transition_count_ff) > MAX_ROWS) begin
         rows_eff = ROW_W'(MAX_ROWS);
      end else begin
         rows_eff = ROW_W'(transition_count_ff);
      end
      if (guard_count_ff == 4'd0) begin
         gc_eff = 4'd1;
      end else if (32'(guard_count_ff) > MAX_GUARDS) begin
         gc_eff = 4'(MAX_GUARDS);
      end else begin
         gc_eff = guard_count_ff;
      end
   end

   assign stride       = STRIDE_W'(gc_eff) + STRIDE_W'(ROW_HEADER_WORDS);
   assign guard_sel    = GUARD_W'(word_ff - STRIDE_W'(ROW_HEADER_WORDS));
   assign row_past_end = (32'(base_ff) + 32'(stride)) > 32'(TABLE_WORDS);

   assign chk_sel.hdr_src   = (word_ff == STRIDE_W'(0));
   assign chk_sel.hdr_req   = (word_ff == STRIDE_W'(1));
   assign chk_sel.mask_test = guard_kind_mask_ff[guard_sel];

   gtt_word_check u_check (
      .sel             (chk_sel),
      .word            (rd_data_ff),
      .current_state   (cur_ff),
      .requested_state (reqst_ff),
      .status          (status_ff[guard_sel]),
      .wildcard_word   (wildcard_value_ff),
      .pass            (chk_pass)
   );

   always_comb begin
      state_in          = state_ff;
      row_in            = row_ff;
      base_in           = base_ff;
      addr_in           = addr_ff;
      word_in           = word_ff;
      cur_in            = cur_ff;
      reqst_in          = reqst_ff;
      grant_in          = grant_ff;
      rsp_valid_in      = rsp_valid_ff && !rsp_ready;
      rsp_next_state_in = rsp_next_state_ff;
      rsp_granted_in    = rsp_granted_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_accept && req_cmd == CMD_EVALUATE) begin
               cur_in   = req_current_state;
               reqst_in = req_requested_state;
               row_in   = '0;
               base_in  = '0;
               grant_in = 1'b0;
               state_in = S_ROW;
            end
         end
         S_ROW: begin
            // Row bases only grow, so once a row overruns the memory the rest do too.
            if (row_ff >= rows_eff || row_past_end) begin
               grant_in = 1'b0;
               state_in = S_DONE;
            end else begin
               addr_in  = ADDR_W'(base_ff);
               word_in  = '0;
               state_in = S_READ;
            end
         end
         S_READ: begin
            state_in = S_CHECK;
         end
         S_CHECK: begin
            if (!chk_pass) begin
               row_in   = row_ff + ROW_W'(1);
               base_in  = base_ff + BASE_W'(stride);
               state_in = S_ROW;
            end else if (word_ff == stride - STRIDE_W'(1)) begin
               grant_in = 1'b1;
               state_in = S_DONE;
            end else begin
               word_in  = word_ff + STRIDE_W'(1);
               addr_in  = addr_ff + ADDR_W'(1);
               state_in = S_READ;
            end
         end
         S_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in      = 1'b1;
               rsp_granted_in    = grant_ff;
               rsp_next_state_in = grant_ff ? reqst_ff : cur_ff;
               state_in          = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      row_ff            <= row_in;
      base_ff           <= base_in;
      addr_ff           <= addr_in;
      word_ff           <= word_in;
      cur_ff            <= cur_in;
      reqst_ff          <= reqst_in;
      grant_ff          <= grant_in;
      rsp_next_state_ff <= rsp_next_state_in;
      rsp_granted_ff    <= rsp_granted_in;
   end

   // Table memory: one write port from the input channel, one registered read port.
   always_ff @(posedge clock) begin
      if (req_accept && req_cmd == CMD_WRITE_TABLE &&
          32'(req_word_index) < TABLE_WORDS) begin
         table_mem[ADDR_W'(req_word_index)] <= req_word_value;
      end
      rd_data_ff <= table_mem[addr_ff];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < MAX_GUARDS; i++) begin
            status_ff[i] <= '0;
         end
      end else if (req_accept && req_cmd == CMD_WRITE_STATUS &&
                   32'(req_guard_index) < MAX_GUARDS) begin
         status_ff[GUARD_W'(req_guard_index)] <= req_word_value;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         transition_count_ff <= 8'd0;
         guard_count_ff      <= 4'd1;
         guard_kind_mask_ff  <= 8'd0;
         wildcard_value_ff   <= 32'hFFFF_FFFF;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            CSR_TRANSITION_COUNT: transition_count_ff <= csr_write_data[7:0];
            CSR_GUARD_COUNT:      guard_count_ff      <= csr_write_data[3:0];
            CSR_GUARD_KIND_MASK:  guard_kind_mask_ff  <= csr_write_data[7:0];
            CSR_WILDCARD_VALUE:   wildcard_value_ff   <= csr_write_data;
            default: begin
            end
         endcase
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_next_state = rsp_next_state_ff;
   assign rsp_granted    = rsp_granted_ff;

   // The word under test always lies inside the current row.
   a_word_in_row: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_CHECK || state_ff == S_READ) |-> (word_ff < stride))
      else $error("word offset beyond the row");

   // A new result only appears as the scan finishes.
   a_result_from_done: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !$past(rsp_valid_ff)) |-> $past(state_ff == S_DONE))
      else $error("result raised outside the finishing step");

   // The row counter never runs past the configured row count.
   a_row_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_READ || state_ff == S_CHECK) |-> (row_ff < rows_eff))
      else $error("scan reading a row beyond the row count");

endmodule

// ----- bench/guarded_transition_table_fsm_tb.sv -----
`timescale 1ns / 100ps
// Self-checking bench for guarded_transition_table_fsm: a short directed script, then randomly
// configured phases whose results are predicted by a behavioural copy of the table scan.
// Depends on gtt_pkg and the guarded_transition_table_fsm RTL.
module guarded_transition_table_fsm_tb;
   import gtt_pkg::*;

   localparam logic [1:0] CMD_UNUSED = 2'd3;
   localparam int SETTLE_CYCLES = 8;
   localparam int LONG_HOLD     = 400;
   localparam int POOL_SIZE     = 6;
   localparam int PHASES        = 11;

   typedef struct packed {
      logic [1:0]  cmd;
      logic [9:0]  word_index;
      logic [2:0]  guard_index;
      logic [31:0] word_value;
      logic [31:0] current_state;
      logic [31:0] requested_state;
   } gtt_item_type;

   typedef struct packed {
      logic [31:0] next_state;
      logic        granted;
   } verdict_type;

   typedef struct packed {
      logic         is_csr;
      logic [1:0]   csr_sel;
      gtt_item_type item;
      logic         typed;
      verdict_type  verdict;
   } script_row_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [1:0]  req_cmd = CMD_WRITE_TABLE;
   logic [9:0]  req_word_index = '0;
   logic [2:0]  req_guard_index = '0;
   logic [31:0] req_word_value = '0;
   logic [31:0] req_current_state = '0;
   logic [31:0] req_requested_state = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [31:0] rsp_next_state;
   logic        rsp_granted;
   logic        csr_write_enable = 1'b0;
   logic [1:0]  csr_index = CSR_TRANSITION_COUNT;
   logic [31:0] csr_write_data = '0;

   // Predictor state: a private copy of the table, the status words and the registers.
   logic [31:0] tt_mem [TABLE_WORDS];
   bit          written [TABLE_WORDS];
   logic [31:0] status_reg [MAX_GUARDS];
   logic [7:0]  cfg_rows = 8'd0;
   logic [3:0]  cfg_guards = 4'd1;
   logic [7:0]  cfg_kinds = 8'd0;
   logic [31:0] cfg_wild = 32'hFFFF_FFFF;

   verdict_type pending_verdicts [$];
   logic [31:0] state_codes [POOL_SIZE];
   int          error_count = 0;
   bit          long_hold_pending = 1'b0;
   bit          calm_tail = 1'b0;

   guarded_transition_table_fsm u_dut (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_ready           (req_ready),
      .req_cmd             (req_cmd),
      .req_word_index      (req_word_index),
      .req_guard_index     (req_guard_index),
      .req_word_value      (req_word_value),
      .req_current_state   (req_current_state),
      .req_requested_state (req_requested_state),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_next_state      (rsp_next_state),
      .rsp_granted         (rsp_granted),
      .csr_write_enable    (csr_write_enable),
      .csr_index           (csr_index),
      .csr_write_data      (csr_write_data)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   function automatic int eff_guards();
      if (cfg_guards == 4'd0) return 1;
      if (cfg_guards > MAX_GUARDS) return MAX_GUARDS;
      return int'(cfg_guards);
   endfunction

   // Number of leading table words that a scan may touch under the present settings.
   function automatic int scan_words();
      int rows, stride;
      rows   = (cfg_rows > MAX_ROWS) ? MAX_ROWS : int'(cfg_rows);
      stride = eff_guards() + ROW_HEADER_WORDS;
      if (rows * stride > TABLE_WORDS) rows = TABLE_WORDS / stride;
      return rows * stride;
   endfunction

   function automatic logic guard_ok(input int j, input logic [31:0] g);
      if (cfg_kinds[j]) return (status_reg[j] & g) == g;
      return status_reg[j] == g || g == cfg_wild;
   endfunction

   function automatic logic grant_lookup(input logic [31:0] cur, input logic [31:0] req);
      int   rows, stride, base, r, j;
      logic all_pass;
      rows   = (cfg_rows > MAX_ROWS) ? MAX_ROWS : int'(cfg_rows);
      stride = eff_guards() + ROW_HEADER_WORDS;
      for (r = 0; r < rows; r++) begin
         base = r * stride;
         // A row that would run off the end of the memory is skipped altogether.
         if (base + stride <= TABLE_WORDS && tt_mem[base] == cur && tt_mem[base + 1] == req) begin
            all_pass = 1'b1;
            for (j = 0; j < stride - ROW_HEADER_WORDS; j++) begin
               if (!guard_ok(j, tt_mem[base + ROW_HEADER_WORDS + j])) all_pass = 1'b0;
            end
            if (all_pass) return 1'b1;
         end
      end
      return 1'b0;
   endfunction

   // Guard words lean towards values that pass against the present status words.
   function automatic logic [31:0] guard_word(input int j);
      case ($urandom_range(0, 5))
         0: return $urandom();
         1: return cfg_wild;
         2: return 32'd0;
         default: return cfg_kinds[j] ? (status_reg[j] & $urandom()) : status_reg[j];
      endcase
   endfunction

   function automatic logic [31:0] layout_word(input int w);
      int stride, pos;
      stride = eff_guards() + ROW_HEADER_WORDS;
      pos    = w % stride;
      if (pos < ROW_HEADER_WORDS) return state_codes[$urandom_range(0, POOL_SIZE - 1)];
      return guard_word(pos - ROW_HEADER_WORDS);
   endfunction

   function automatic gtt_item_type random_item();
      gtt_item_type it;
      int           span, stride, base, j, pick;
      span   = scan_words();
      stride = eff_guards() + ROW_HEADER_WORDS;
      base   = (span > 0) ? stride * $urandom_range(0, span / stride - 1) : 0;
      it.cmd             = CMD_EVALUATE;
      it.word_index      = 10'($urandom());
      it.guard_index     = 3'($urandom());
      it.word_value      = $urandom();
      it.current_state   = $urandom();
      it.requested_state = $urandom();
      pick = $urandom_range(0, 99);
      if (pick < 45) begin
         pick = $urandom_range(0, 9);
         if (span > 0 && pick < 6) begin
            it.current_state   = tt_mem[base];
            it.requested_state = tt_mem[base + 1];
         end else if (pick < 9) begin
            it.current_state   = state_codes[$urandom_range(0, POOL_SIZE - 1)];
            it.requested_state = state_codes[$urandom_range(0, POOL_SIZE - 1)];
         end
      end else if (pick < 65) begin
         it.cmd = CMD_WRITE_TABLE;
         if (span > 0 && $urandom_range(0, 3) != 0)
            it.word_index = 10'(base + $urandom_range(0, stride - 1));
         it.word_value = layout_word(int'(it.word_index));
      end else if (pick < 95) begin
         it.cmd = CMD_WRITE_STATUS;
         j = int'(it.guard_index);
         case ($urandom_range(0, 4))
            0: it.word_value = 32'd0;
            1: it.word_value = 32'hFFFF_FFFF;
            2: ;
            default: begin
               // Make some row's guard pass from now on.
               if (span > 0 && j < stride - ROW_HEADER_WORDS) begin
                  it.word_value = tt_mem[base + ROW_HEADER_WORDS + j];
                  if (cfg_kinds[j]) it.word_value = it.word_value | $urandom();
               end
            end
         endcase
      end else begin
         it.cmd = CMD_UNUSED;
      end
      return it;
   endfunction

   function automatic script_row_type step_item(input logic [1:0] cmd, input logic [9:0] widx,
                                                input logic [2:0] gidx, input logic [31:0] val);
      script_row_type row;
      row = '0;
      row.item.cmd             = cmd;
      row.item.word_index      = widx;
      row.item.guard_index     = gidx;
      row.item.word_value      = val;
      row.item.current_state   = ~val;
      row.item.requested_state = val;
      return row;
   endfunction

   function automatic script_row_type step_eval(input logic [31:0] cur, input logic [31:0] req,
                                                input logic [31:0] next, input logic granted);
      script_row_type row;
      row = '0;
      row.item.cmd             = CMD_EVALUATE;
      row.item.current_state   = cur;
      row.item.requested_state = req;
      row.typed                = 1'b1;
      row.verdict.next_state   = next;
      row.verdict.granted      = granted;
      return row;
   endfunction

   function automatic script_row_type step_check(input logic [31:0] cur,
                                                 input logic [31:0] req);
      script_row_type row;
      row       = step_eval(cur, req, 32'd0, 1'b0);
      row.typed = 1'b0;
      return row;
   endfunction

   function automatic script_row_type step_csr(input logic [1:0] sel, input logic [31:0] value);
      script_row_type row;
      row = '0;
      row.is_csr          = 1'b1;
      row.csr_sel         = sel;
      row.item.word_value = value;
      return row;
   endfunction

   // Called at a falling edge; returns at a falling edge with the item accepted.
   task automatic send_item(input gtt_item_type it, input logic typed,
                            input verdict_type typed_v);
      verdict_type v;
      req_valid           <= 1'b1;
      req_cmd             <= it.cmd;
      req_word_index      <= it.word_index;
      req_guard_index     <= it.guard_index;
      req_word_value      <= it.word_value;
      req_current_state   <= it.current_state;
      req_requested_state <= it.requested_state;
      do @(posedge clock); while (!req_ready);
      case (it.cmd)
         CMD_WRITE_TABLE: begin
            tt_mem[it.word_index]  = it.word_value;
            written[it.word_index] = 1'b1;
         end
         CMD_WRITE_STATUS: status_reg[it.guard_index] = it.word_value;
         CMD_EVALUATE: begin
            v.granted    = grant_lookup(it.current_state, it.requested_state);
            v.next_state = v.granted ? it.requested_state : it.current_state;
            pending_verdicts.push_back(typed ? typed_v : v);
         end
         default: ;
      endcase
      @(negedge clock);
      if (!calm_tail && $urandom_range(0, 5) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 16)) @(negedge clock);
      end
   endtask

   task automatic write_csr(input logic [1:0] sel, input logic [31:0] value);
      csr_write_enable <= 1'b1;
      csr_index        <= sel;
      csr_write_data   <= value;
      case (sel)
         CSR_TRANSITION_COUNT: cfg_rows   = value[7:0];
         CSR_GUARD_COUNT:      cfg_guards = value[3:0];
         CSR_GUARD_KIND_MASK:  cfg_kinds  = value[7:0];
         CSR_WILDCARD_VALUE:   cfg_wild   = value;
         default: ;
      endcase
      @(negedge clock);
      csr_write_enable <= 1'b0;
      @(negedge clock);
   endtask

   // Writes give no result, so a settling wait after the last result lets the last of them land.
   task automatic wait_drained();
      req_valid <= 1'b0;
      while (pending_verdicts.size() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   always begin : rsp_pacing
      @(negedge clock);
      if (long_hold_pending) begin
         long_hold_pending = 1'b0;
         rsp_ready <= 1'b0;
         repeat (LONG_HOLD) @(negedge clock);
         rsp_ready <= 1'b1;
      end else if (!calm_tail && $urandom_range(0, 7) == 0) begin
         rsp_ready <= 1'b0;
         repeat ($urandom_range(1, 16)) @(negedge clock);
         rsp_ready <= 1'b1;
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   always @(posedge clock) begin : result_check
      verdict_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_verdicts.size() == 0) begin
            $error("result with nothing outstanding: next_state %h granted %b",
                   rsp_next_state, rsp_granted);
            error_count++;
         end else begin
            want = pending_verdicts.pop_front();
            if (rsp_next_state !== want.next_state) begin
               $error("next_state: expected %h, got %h", want.next_state, rsp_next_state);
               error_count++;
            end
            if (rsp_granted !== want.granted) begin
               $error("granted: expected %b, got %b", want.granted, rsp_granted);
               error_count++;
            end
         end
      end
   end

   initial begin : stimulus
      script_row_type script [$];
      gtt_item_type   it;
      int             p, w, n_items, done, span;
      logic [7:0]     rows;
      logic [3:0]     guards;
      logic [7:0]     kinds;
      logic [31:0]    wild;

      foreach (status_reg[i]) status_reg[i] = 32'd0;

      // Reset settings: no rows, one equality guard, all-ones wildcard, status words zero.
      script.push_back(step_eval(32'd0, 32'hFFFF_FFFF, 32'd0, 1'b0));
      script.push_back(step_eval(32'hFFFF_FFFF, 32'd0, 32'hFFFF_FFFF, 1'b0));
      script.push_back(step_item(CMD_UNUSED, 10'h3FF, 3'd7, 32'hFFFF_FFFF));
      script.push_back(step_item(CMD_WRITE_TABLE, 10'd0, 3'd0, 32'd5));
      script.push_back(step_item(CMD_WRITE_TABLE, 10'd1, 3'd0, 32'd9));
      script.push_back(step_item(CMD_WRITE_TABLE, 10'd2, 3'd0, 32'hFFFF_FFFF));
      script.push_back(step_item(CMD_WRITE_TABLE, 10'd3, 3'd0, 32'd5));
      script.push_back(step_item(CMD_WRITE_TABLE, 10'd4, 3'd0, 32'd7));
      script.push_back(step_item(CMD_WRITE_TABLE, 10'd5, 3'd0, 32'd0));
      script.push_back(step_csr(CSR_TRANSITION_COUNT, 32'd2));
      script.push_back(step_eval(32'd5, 32'd9, 32'd9, 1'b1));
      script.push_back(step_eval(32'd5, 32'd7, 32'd7, 1'b1));
      script.push_back(step_eval(32'd9, 32'd5, 32'd9, 1'b0));
      script.push_back(step_item(CMD_WRITE_STATUS, 10'd0, 3'd0, 32'hFFFF_FFFF));
      script.push_back(step_eval(32'd5, 32'd7, 32'd5, 1'b0));
      script.push_back(step_eval(32'd5, 32'd9, 32'd9, 1'b1));
      script.push_back(step_csr(CSR_GUARD_KIND_MASK, 32'd1));
      script.push_back(step_eval(32'd5, 32'd7, 32'd7, 1'b1));
      script.push_back(step_item(CMD_WRITE_STATUS, 10'd0, 3'd0, 32'd0));
      script.push_back(step_eval(32'd5, 32'd9, 32'd5, 1'b0));
      script.push_back(step_csr(CSR_WILDCARD_VALUE, 32'd0));
      script.push_back(step_csr(CSR_GUARD_KIND_MASK, 32'd0));
      script.push_back(step_check(32'd5, 32'd9));
      script.push_back(step_check(32'd5, 32'd7));
      script.push_back(step_item(CMD_WRITE_TABLE, 10'h3FF, 3'd0, 32'h8000_0001));
      script.push_back(step_item(CMD_WRITE_STATUS, 10'd0, 3'd7, 32'hA5A5_5A5A));

      repeat (2) @(negedge clock);
      reset <= 1'b0;

      foreach (script[i]) begin
         if (script[i].is_csr) begin
            wait_drained();
            write_csr(script[i].csr_sel, script[i].item.word_value);
         end else begin
            send_item(script[i].item, script[i].typed, script[i].verdict);
         end
      end

      // Filling the table for the larger settings accounts for about a thousand writes.
      for (p = 0; p < PHASES; p++) begin
         wait_drained();
         state_codes[0] = 32'd0;
         state_codes[1] = 32'hFFFF_FFFF;
         for (w = 2; w < POOL_SIZE; w++) state_codes[w] = $urandom();
         kinds   = 8'($urandom());
         wild    = $urandom();
         n_items = 30;
         case (p)
            0: begin rows = 8'd4;   guards = 4'd1;  kinds = 8'h00; wild = 32'hFFFF_FFFF; end
            1: begin rows = 8'd12;  guards = 4'd2;  kinds = 8'hFF; wild = 32'd0; end
            2: begin rows = 8'd0;   guards = 4'd3;  n_items = 15; end
            3: begin rows = 8'd20;  guards = 4'd0;  wild = state_codes[2]; n_items = 40; end
            4: begin rows = 8'd8;   guards = 4'd8;  kinds = 8'h55; wild = 32'hFFFF_FFFF; end
            5: begin rows = 8'd16;  guards = 4'd15; kinds = 8'hAA; end
            // The largest settings are slow to scan, so they get few items.
            6: begin rows = 8'd255; guards = 4'd8;  n_items = 15; end
            7: begin rows = 8'd128; guards = 4'd1;  n_items = 15; end
            8: begin rows = 8'd6;   guards = 4'd5;  n_items = 30; end
            9: begin rows = 8'd30;  guards = 4'd4;  n_items = 30; end
            default: begin
               rows = 8'd10; guards = 4'd2; kinds = 8'hFF; wild = 32'hFFFF_FFFF;
               n_items = 40;
               calm_tail = 1'b1;
            end
         endcase
         write_csr(CSR_TRANSITION_COUNT, {24'($urandom()), rows});
         write_csr(CSR_GUARD_COUNT, {28'($urandom()), guards});
         write_csr(CSR_GUARD_KIND_MASK, {24'($urandom()), kinds});
         write_csr(CSR_WILDCARD_VALUE, wild);

         // Every word a scan might read must hold a written value before any evaluate.
         span = scan_words();
         for (w = 0; w < span; w++) begin
            if (!written[w]) begin
               it            = random_item();
               it.cmd        = CMD_WRITE_TABLE;
               it.word_index = 10'(w);
               it.word_value = layout_word(w);
               send_item(it, 1'b0, '0);
            end
         end

         if (p == 3) long_hold_pending = 1'b1;
         done = 0;
         while (done < n_items) begin
            it = random_item();
            send_item(it, 1'b0, '0);
            if (it.cmd != CMD_UNUSED) done++;
         end
      end

      wait_drained();
      if (error_count == 0) begin
         $display("guarded_transition_table_fsm_tb: done, clean");
      end else begin
         $display("guarded_transition_table_fsm_tb: done, errors");
      end
      $finish;
   end

   // Far beyond the slowest legal run, even with every item a full-length scan.
   initial begin : watchdog
      #300_000_000;
      $display("guarded_transition_table_fsm_tb: done, errors");
      $finish;
   end

endmodule
